// ===== hw/rtl/lbk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbk_pkg
// Shared types, constants and round functions of the lblock encryption pipe.
// ----------------------------------------------------------------------------
package lbk_pkg;

  localparam int MAX_ROUNDS_DEF = 32;
  localparam int CFG_W          = 6;
  localparam int KEY_W          = 80;
  localparam int HALF_W         = 32;

  typedef struct packed {
    logic [HALF_W-1:0] left;
    logic [HALF_W-1:0] right;
    logic [15:0]       khi;
    logic [63:0]       klo;
  } beat_t;

  localparam logic [3:0] SBOX [10][16] = '{
    '{4'd14, 4'd9,  4'd15, 4'd0,  4'd13, 4'd4,  4'd10, 4'd11,
      4'd1,  4'd2,  4'd8,  4'd3,  4'd7,  4'd6,  4'd12, 4'd5},
    '{4'd4,  4'd11, 4'd14, 4'd9,  4'd15, 4'd13, 4'd0,  4'd10,
      4'd7,  4'd12, 4'd5,  4'd6,  4'd2,  4'd8,  4'd1,  4'd3},
    '{4'd1,  4'd14, 4'd7,  4'd12, 4'd15, 4'd13, 4'd0,  4'd6,
      4'd11, 4'd5,  4'd9,  4'd3,  4'd2,  4'd4,  4'd8,  4'd10},
    '{4'd7,  4'd6,  4'd8,  4'd11, 4'd0,  4'd15, 4'd3,  4'd14,
      4'd9,  4'd10, 4'd12, 4'd13, 4'd5,  4'd2,  4'd4,  4'd1},
    '{4'd14, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd12, 4'd13,
      4'd1,  4'd8,  4'd4,  4'd9,  4'd11, 4'd10, 4'd6,  4'd3},
    '{4'd2,  4'd13, 4'd11, 4'd12, 4'd15, 4'd14, 4'd0,  4'd9,
      4'd7,  4'd10, 4'd6,  4'd3,  4'd1,  4'd8,  4'd4,  4'd5},
    '{4'd11, 4'd9,  4'd4,  4'd14, 4'd0,  4'd15, 4'd10, 4'd13,
      4'd6,  4'd12, 4'd5,  4'd7,  4'd3,  4'd8,  4'd1,  4'd2},
    '{4'd13, 4'd10, 4'd15, 4'd0,  4'd14, 4'd4,  4'd9,  4'd11,
      4'd2,  4'd1,  4'd8,  4'd3,  4'd7,  4'd5,  4'd12, 4'd6},
    '{4'd8,  4'd7,  4'd14, 4'd5,  4'd15, 4'd13, 4'd0,  4'd6,
      4'd11, 4'd12, 4'd9,  4'd10, 4'd2,  4'd4,  4'd1,  4'd3},
    '{4'd11, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd9,  4'd13,
      4'd4,  4'd8,  4'd1,  4'd12, 4'd14, 4'd10, 4'd3,  4'd6}
  };

  // output nibble slot j (0 = most significant) takes input slot PERM[j]
  localparam logic [2:0] PERM [8] = '{3'd1, 3'd3, 3'd0, 3'd2, 3'd5, 3'd7, 3'd4, 3'd6};

  function automatic logic [HALF_W-1:0] round_fn(logic [HALF_W-1:0] x,
                                                 logic [HALF_W-1:0] rk);
    logic [HALF_W-1:0] y;
    logic [HALF_W-1:0] s;
    logic [HALF_W-1:0] p;
    y = x ^ rk;
    s = '0;
    p = '0;
    for (int j = 0; j < 8; j++) begin
      s[4*j +: 4] = SBOX[j][y[4*j +: 4]];
    end
    for (int j = 0; j < 8; j++) begin
      p[28-4*j +: 4] = s[28-4*int'(PERM[j]) +: 4];
    end
    return p;
  endfunction

  function automatic logic [KEY_W-1:0] key_update(logic [KEY_W-1:0] k, logic [4:0] idx);
    logic [KEY_W-1:0] r;
    r = {k[50:0], k[79:51]};
    r[79:76] = SBOX[9][r[79:76]];
    r[75:72] = SBOX[8][r[75:72]];
    r[50:46] = r[50:46] ^ idx;
    return r;
  endfunction

endpackage

// ===== hw/rtl/lbk_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbk_cfg
// Round count register, clamped to one up to the pipeline depth.
// ----------------------------------------------------------------------------
module lbk_cfg #(
  parameter int MAX_ROUNDS = lbk_pkg::MAX_ROUNDS_DEF,
  parameter int RC_W       = $clog2(MAX_ROUNDS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [lbk_pkg::CFG_W-1:0] cfg_wdata,
  output logic [RC_W-1:0]          round_count
);

  logic [RC_W-1:0] round_count_next;

  always_comb begin
    if (cfg_wdata > lbk_pkg::CFG_W'(MAX_ROUNDS)) begin
      round_count_next = RC_W'(MAX_ROUNDS);
    end else if (cfg_wdata == '0) begin
      round_count_next = RC_W'(1);
    end else begin
      round_count_next = RC_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_count <= RC_W'(MAX_ROUNDS);
    end else if (cfg_we) begin
      round_count <= round_count_next;
    end
  end

endmodule

// ===== hw/rtl/lbk_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbk_round
// One registered stage: key schedule step and feistel round, or pass-through.
// ----------------------------------------------------------------------------
module lbk_round #(
  parameter int ROUND_IDX = 0,
  parameter int RC_W      = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [RC_W-1:0]    round_count,
  input  logic               up_valid,
  input  lbk_pkg::beat_t     up_beat,
  output logic               up_ready,
  output logic               dn_valid,
  output lbk_pkg::beat_t     dn_beat,
  input  logic               dn_ready
);

  logic                            active;
  logic [lbk_pkg::KEY_W-1:0]       key;
  logic [lbk_pkg::HALF_W-1:0]      t;
  lbk_pkg::beat_t                  beat_next;

  assign active   = round_count > RC_W'(ROUND_IDX);
  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    key = {up_beat.khi, up_beat.klo};
    if (ROUND_IDX > 0) begin
      key = lbk_pkg::key_update(key, 5'(ROUND_IDX));
    end
    t = {up_beat.right[23:0], up_beat.right[31:24]}
        ^ lbk_pkg::round_fn(up_beat.left, key[79:48]);
    if (active) begin
      beat_next.left  = t;
      beat_next.right = up_beat.left;
      beat_next.khi   = key[79:64];
      beat_next.klo   = key[63:0];
    end else begin
      beat_next = up_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_beat <= beat_next;
    end
  end

endmodule

// ===== hw/rtl/lblock_block_encrypt_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lblock_block_encrypt_top
// LBlock 64/80 encryption with a configurable round count, one stage per round.
// ----------------------------------------------------------------------------
// The block takes a plaintext beat with its own key every cycle unless stalled;
// each beat passes all MAX_ROUNDS stages whatever round_count holds: the
// pipeline is unrolled into one register stage per round, and stages past the
// configured count hand the beat on unchanged. Each stage holds its beat while
// the next is full, so the input is stalled only once every stage is occupied
// and the output is stalled. Write round_count only while the pipe is empty.
module lblock_block_encrypt_top #(
  parameter int MAX_ROUNDS = lbk_pkg::MAX_ROUNDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [lbk_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [63:0]               block_in,
  input  logic [15:0]               key_top,
  input  logic [63:0]               key_rest,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [63:0]               block_out
);

  localparam int RC_W = $clog2(MAX_ROUNDS + 1);

  logic [RC_W-1:0]   round_count;
  logic [MAX_ROUNDS:0] valid;
  logic [MAX_ROUNDS:0] ready;
  lbk_pkg::beat_t    beat [MAX_ROUNDS+1];

  lbk_cfg #(
    .MAX_ROUNDS (MAX_ROUNDS),
    .RC_W       (RC_W)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .round_count (round_count)
  );

  assign valid[0]      = in_valid;
  assign beat[0].left  = block_in[63:32];
  assign beat[0].right = block_in[31:0];
  assign beat[0].khi   = key_top;
  assign beat[0].klo   = key_rest;
  assign in_stall      = !ready[0];

  for (genvar r = 0; r < MAX_ROUNDS; r++) begin : g_round
    lbk_round #(
      .ROUND_IDX (r),
      .RC_W      (RC_W)
    ) u_round (
      .clk         (clk),
      .rst         (rst),
      .round_count (round_count),
      .up_valid    (valid[r]),
      .up_beat     (beat[r]),
      .up_ready    (ready[r]),
      .dn_valid    (valid[r+1]),
      .dn_beat     (beat[r+1]),
      .dn_ready    (ready[r+1])
    );
  end

  assign ready[MAX_ROUNDS] = !out_stall;
  assign out_valid         = valid[MAX_ROUNDS];
  assign block_out         = {beat[MAX_ROUNDS].right, beat[MAX_ROUNDS].left};

  // round count stays within one and the pipeline depth
  a_rc_range: assert property (@(posedge clk) disable iff (rst)
    (round_count >= RC_W'(1)) && (round_count <= RC_W'(MAX_ROUNDS)))
    else $error("round count out of range");

  // a zero write runs a single round
  a_rc_zero: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_wdata == '0) |=> (round_count == RC_W'(1)))
    else $error("zero round count not raised to one");

  // input backs up only when every stage is full and the output is held
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&valid[MAX_ROUNDS:1]) && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule
